>>> rtl/core/lwpb_pkg.sv
`timescale 1ns / 1ps

package lwpb_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DISPLAY_CONTROL  = 3'd0,
      CSR_WIN0_RECT        = 3'd1,
      CSR_WIN1_RECT        = 3'd2,
      CSR_WINDOW_LAYERS    = 3'd3,
      CSR_BLEND_CONTROL    = 3'd4,
      CSR_BLEND_ALPHA      = 3'd5,
      CSR_BRIGHTNESS_LEVEL = 3'd6,
      CSR_BACKDROP_COLOR   = 3'd7
   } csr_index_type;

   // Color effect selected by the top two bits of the blend control.
   typedef enum logic [1:0] {
      EFFECT_NONE     = 2'd0,
      EFFECT_ALPHA    = 2'd1,
      EFFECT_BRIGHTEN = 2'd2,
      EFFECT_DARKEN   = 2'd3
   } effect_type;

   localparam logic [2:0]  LAYER_SPRITE   = 3'd4;
   localparam logic [2:0]  LAYER_BACKDROP = 3'd5;
   localparam logic [2:0]  RANK_BACKDROP  = 3'd4;
   localparam logic [5:0]  MASK_ALL       = 6'h3F;
   localparam int unsigned EFFECTS_BIT    = 5;
   localparam logic [14:0] COLOR_WHITE    = 15'h7FFF;
   localparam logic [4:0]  CH_MAX         = 5'd31;
   localparam logic [4:0]  BRIGHT_MAX     = 5'd16;

   // Window configuration seen by the mask logic.
   typedef struct packed {
      logic [2:0]  win_enable;     // window 0, window 1, sprite window
      logic [31:0] win0_rect;
      logic [31:0] win1_rect;
      logic [23:0] window_layers;
   } win_cfg_type;

   // Effect configuration seen by the blend logic.
   typedef struct packed {
      logic       force_blank;
      logic [7:0] blend_control;
      logic [9:0] blend_alpha;
      logic [4:0] brightness_level;
   } blend_cfg_type;

   // One candidate beat with its window mask resolved.
   typedef struct packed {
      logic [7:0]  x;
      logic [7:0]  y;
      logic [2:0]  layer_id;
      logic [1:0]  layer_prio;
      logic [14:0] color;
      logic        present;
      logic        semi;
      logic        last;
      logic [5:0]  mask;
   } cand_type;

   // Finished ranking of one pixel, handed to the blend stage.
   typedef struct packed {
      logic [14:0] best_color;
      logic [14:0] second_color;
      logic [2:0]  best_layer;
      logic        winner_semi;
      logic [5:0]  mask;
      logic [7:0]  x;
      logic [7:0]  y;
   } pixel_type;

endpackage

>>> rtl/core/lwpb_window.sv
`timescale 1ns / 1ps

module lwpb_window (
   input  logic                     clock,
   input  logic                     reset,
   input  lwpb_pkg::win_cfg_type    cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_pixel_x,
   input  logic [7:0]               req_pixel_y,
   input  logic                     req_obj_window_hit,
   input  logic [2:0]               req_layer_id,
   input  logic [1:0]               req_layer_priority,
   input  logic [14:0]              req_layer_color,
   input  logic                     req_candidate_present,
   input  logic                     req_semi_transparent,
   input  logic                     req_last_of_pixel,
   output logic                     out_valid,
   output lwpb_pkg::cand_type       out_item,
   input  logic                     out_ready
);
   import lwpb_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   cand_type item_ff;
   cand_type item_in;
   logic     in_win0;
   logic     in_win1;
   logic [5:0] mask;

   // Span test with exclusive end; a start past the end wraps around.
   function automatic logic in_span(input logic [7:0] c, input logic [7:0] s,
                                    input logic [7:0] e);
      if (s <= e) begin
         return (c >= s) && (c < e);
      end else begin
         return (c >= s) || (c < e);
      end
   endfunction

   // Rectangle hits for both windows.
   assign in_win0 = in_span(req_pixel_x, cfg.win0_rect[7:0], cfg.win0_rect[15:8]) &&
                    in_span(req_pixel_y, cfg.win0_rect[23:16], cfg.win0_rect[31:24]);
   assign in_win1 = in_span(req_pixel_x, cfg.win1_rect[7:0], cfg.win1_rect[15:8]) &&
                    in_span(req_pixel_y, cfg.win1_rect[23:16], cfg.win1_rect[31:24]);

   // Window priority: window 0, window 1, sprite window, then outside.
   always_comb begin
      if (cfg.win_enable == 3'b000) begin
         mask = MASK_ALL;
      end else if (cfg.win_enable[0] && in_win0) begin
         mask = cfg.window_layers[5:0];
      end else if (cfg.win_enable[1] && in_win1) begin
         mask = cfg.window_layers[11:6];
      end else if (cfg.win_enable[2] && req_obj_window_hit) begin
         mask = cfg.window_layers[23:18];
      end else begin
         mask = cfg.window_layers[17:12];
      end
   end

   // Assemble the registered candidate.
   always_comb begin
      item_in.x          = req_pixel_x;
      item_in.y          = req_pixel_y;
      item_in.layer_id   = req_layer_id;
      item_in.layer_prio = req_layer_priority;
      item_in.color      = req_layer_color;
      item_in.present    = req_candidate_present;
      item_in.semi       = req_semi_transparent;
      item_in.last       = req_last_of_pixel;
      item_in.mask       = mask;
   end

   // Input stage: takes a new beat whenever the held one moves on.
   assign req_ready = !valid_ff || out_ready;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> rtl/core/lwpb_rank.sv
`timescale 1ns / 1ps

module lwpb_rank (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [14:0]           backdrop_color,
   input  logic                  in_valid,
   input  lwpb_pkg::cand_type    in_item,
   output logic                  in_ready,
   output logic                  out_valid,
   output lwpb_pkg::pixel_type   out_pixel,
   input  logic                  out_ready
);
   import lwpb_pkg::*;

   logic        pixel_start_ff, pixel_start_in;
   logic [14:0] best_color_ff, best_color_in;
   logic [2:0]  best_layer_ff, best_layer_in;
   logic [2:0]  best_rank_ff, best_rank_in;
   logic [14:0] second_color_ff, second_color_in;
   logic [2:0]  second_rank_ff, second_rank_in;
   logic        winner_semi_ff, winner_semi_in;
   logic        pix_valid_ff, pix_valid_in;
   pixel_type   pix_ff, pix_in;

   logic [14:0] cur_best_color;
   logic [2:0]  cur_best_layer;
   logic [2:0]  cur_best_rank;
   logic [14:0] cur_second_color;
   logic [2:0]  cur_second_rank;
   logic        cur_winner_semi;
   logic [2:0]  prio;
   logic        layer_ok;
   logic        take;
   logic        in_go;
   logic        slot_free;

   // The first beat of a pixel starts from the backdrop.
   always_comb begin
      if (pixel_start_ff) begin
         cur_best_color   = backdrop_color;
         cur_best_layer   = LAYER_BACKDROP;
         cur_best_rank    = RANK_BACKDROP;
         cur_second_color = backdrop_color;
         cur_second_rank  = RANK_BACKDROP;
         cur_winner_semi  = 1'b0;
      end else begin
         cur_best_color   = best_color_ff;
         cur_best_layer   = best_layer_ff;
         cur_best_rank    = best_rank_ff;
         cur_second_color = second_color_ff;
         cur_second_rank  = second_rank_ff;
         cur_winner_semi  = winner_semi_ff;
      end
   end

   // A candidate counts if present, a real layer, enabled by the window,
   // and not a sprite that falls behind the current best.
   assign prio     = {1'b0, in_item.layer_prio};
   assign layer_ok = (in_item.layer_id <= LAYER_SPRITE) &&
                     (((in_item.mask >> in_item.layer_id) & 6'd1) != 6'd0);
   assign take     = in_item.present && layer_ok &&
                     !((in_item.layer_id == LAYER_SPRITE) && (prio > cur_best_rank));

   // Handshake: only the last beat of a pixel needs room downstream.
   assign slot_free = !pix_valid_ff || out_ready;
   assign in_ready  = !in_item.last || slot_free;
   assign in_go     = in_valid && in_ready;

   // Best and second update; the later candidate wins ties.
   always_comb begin
      best_color_in   = cur_best_color;
      best_layer_in   = cur_best_layer;
      best_rank_in    = cur_best_rank;
      second_color_in = cur_second_color;
      second_rank_in  = cur_second_rank;
      winner_semi_in  = cur_winner_semi;
      if (take && (prio <= cur_best_rank)) begin
         second_color_in = cur_best_color;
         second_rank_in  = cur_best_rank;
         best_color_in   = in_item.color;
         best_layer_in   = in_item.layer_id;
         best_rank_in    = prio;
         winner_semi_in  = (in_item.layer_id == LAYER_SPRITE) && in_item.semi;
      end else if (take && (prio <= cur_second_rank)) begin
         second_color_in = in_item.color;
         second_rank_in  = prio;
      end
      pixel_start_in = in_item.last;
   end

   // Snapshot of the finished pixel.
   always_comb begin
      pix_in.best_color   = best_color_in;
      pix_in.second_color = second_color_in;
      pix_in.best_layer   = best_layer_in;
      pix_in.winner_semi  = winner_semi_in;
      pix_in.mask         = in_item.mask;
      pix_in.x            = in_item.x;
      pix_in.y            = in_item.y;
      pix_valid_in        = pix_valid_ff;
      if (slot_free) begin
         pix_valid_in = in_go && in_item.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_start_ff <= 1'b1;
         pix_valid_ff   <= 1'b0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         if (in_go) begin
            pixel_start_ff <= pixel_start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_go) begin
         best_color_ff   <= best_color_in;
         best_layer_ff   <= best_layer_in;
         best_rank_ff    <= best_rank_in;
         second_color_ff <= second_color_in;
         second_rank_ff  <= second_rank_in;
         winner_semi_ff  <= winner_semi_in;
      end
      if (in_go && in_item.last) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid = pix_valid_ff;
   assign out_pixel = pix_ff;

   // A beat that is not the last keeps the pixel open.
   a_pixel_open: assert property (@(posedge clock) disable iff (reset)
      in_go && !in_item.last |=> !pixel_start_ff)
      else $error("pixel closed on a beat that was not the last");

   // The last beat closes the pixel and hands a result downstream.
   a_pixel_close: assert property (@(posedge clock) disable iff (reset)
      in_go && in_item.last |=> pixel_start_ff && pix_valid_ff)
      else $error("last beat did not close the pixel");

   // The best candidate never ranks behind the second.
   a_rank_order: assert property (@(posedge clock) disable iff (reset)
      !pixel_start_ff |-> best_rank_ff <= second_rank_ff)
      else $error("best rank behind second rank");

endmodule

>>> rtl/core/lwpb_blend.sv
`timescale 1ns / 1ps

module lwpb_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  lwpb_pkg::blend_cfg_type cfg,
   input  logic                    in_valid,
   input  lwpb_pkg::pixel_type     in_pixel,
   output logic                    in_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [14:0]             rsp_out_color,
   output logic                    rsp_was_blended,
   output logic                    rsp_fully_masked,
   output logic [7:0]              rsp_out_x,
   output logic [7:0]              rsp_out_y
);
   import lwpb_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [14:0] color_ff, color_in;
   logic        blended_ff, blended_in;
   logic        masked_ff, masked_in;
   logic [7:0]  x_ff;
   logic [7:0]  y_ff;

   effect_type  eff;
   logic        first;
   logic        forced;
   logic [4:0]  amt;
   logic [4:0]  wa;
   logic [4:0]  wb;
   logic [14:0] mixed;
   logic [14:0] shaded;

   // Weighted sum of two channels in sixteenths, saturated.
   function automatic logic [4:0] mix_ch(input logic [4:0] t, input logic [4:0] b,
                                         input logic [4:0] w_top, input logic [4:0] w_bot);
      logic [9:0]  pa;
      logic [9:0]  pb;
      logic [10:0] sum;
      pa  = 10'(t) * 10'(w_top);
      pb  = 10'(b) * 10'(w_bot);
      sum = 11'(pa) + 11'(pb);
      return (sum[10:4] > 7'(CH_MAX)) ? CH_MAX : sum[8:4];
   endfunction

   // Move a channel toward white or black by amt sixteenths.
   function automatic logic [4:0] shade_ch(input logic [4:0] ch, input logic [4:0] amt_s,
                                           input logic up);
      logic [9:0] prod;
      if (up) begin
         prod = 10'(CH_MAX - ch) * 10'(amt_s);
         return ch + prod[8:4];
      end else begin
         prod = 10'(ch) * 10'(amt_s);
         return ch - prod[8:4];
      end
   endfunction

   assign eff    = effect_type'(cfg.blend_control[7:6]);
   assign first  = (in_pixel.best_layer <= LAYER_BACKDROP) &&
                   cfg.blend_control[in_pixel.best_layer];
   assign forced = (in_pixel.best_layer == LAYER_SPRITE) && in_pixel.winner_semi;
   assign amt    = (cfg.brightness_level > BRIGHT_MAX) ? BRIGHT_MAX : cfg.brightness_level;
   assign wa     = cfg.blend_alpha[4:0];
   assign wb     = cfg.blend_alpha[9:5];

   // Per-channel alpha mix and brightness shade.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mixed[i*5 +: 5]  = mix_ch(in_pixel.best_color[i*5 +: 5],
                                   in_pixel.second_color[i*5 +: 5], wa, wb);
         shaded[i*5 +: 5] = shade_ch(in_pixel.best_color[i*5 +: 5], amt,
                                     eff == EFFECT_BRIGHTEN);
      end
   end

   // Effect selection; forced blank overrides everything.
   always_comb begin
      color_in   = in_pixel.best_color;
      blended_in = 1'b0;
      masked_in  = (in_pixel.mask == 6'd0);
      if (cfg.force_blank) begin
         color_in  = COLOR_WHITE;
         masked_in = 1'b0;
      end else if (in_pixel.mask[EFFECTS_BIT]) begin
         if (forced || ((eff == EFFECT_ALPHA) && first)) begin
            color_in   = mixed;
            blended_in = 1'b1;
         end else if (((eff == EFFECT_BRIGHTEN) || (eff == EFFECT_DARKEN)) && first &&
                      (amt != 5'd0)) begin
            color_in   = shaded;
            blended_in = 1'b1;
         end
      end
   end

   // Output register: refills in the same cycle the held beat leaves.
   assign in_ready     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = in_ready ? in_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         color_ff   <= color_in;
         blended_ff <= blended_in;
         masked_ff  <= masked_in;
         x_ff       <= in_pixel.x;
         y_ff       <= in_pixel.y;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_color    = color_ff;
   assign rsp_was_blended  = blended_ff;
   assign rsp_fully_masked = masked_ff;
   assign rsp_out_x        = x_ff;
   assign rsp_out_y        = y_ff;

   // A blended pixel had effects enabled, so its mask was not empty.
   a_blend_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_blended |-> !rsp_fully_masked)
      else $error("blended pixel reported as fully masked");

   // A pixel taken in shows up at the output on the next cycle.
   a_blend_load: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> rsp_valid)
      else $error("accepted pixel missing at the output");

endmodule

>>> rtl/core/layer_window_priority_blend.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+--------------------------------------
// req_      | in        | req_valid / req_ready  | one layer candidate per beat
// rsp_      | out       | rsp_valid / rsp_ready  | one blended pixel per last candidate
// csr_      | in        | csr_valid / csr_ready  | register index and write data
//
// One candidate beat is taken per cycle unless an output stall holds it back. A pixel's
// result moves from the input register that accepts its last candidate to the ranking
// snapshot and then to the blend output register.
// Reset is synchronous and active high; it clears the configuration registers and the
// pipeline valids and arms the ranking to start from the backdrop.
// An output stall backs up only through beats that close a pixel.

module layer_window_priority_blend (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_pixel_x,
   input  logic [7:0]                         req_pixel_y,
   input  logic                               req_obj_window_hit,
   input  logic [2:0]                         req_layer_id,
   input  logic [1:0]                         req_layer_priority,
   input  logic [14:0]                        req_layer_color,
   input  logic                               req_candidate_present,
   input  logic                               req_semi_transparent,
   input  logic                               req_last_of_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [14:0]                        rsp_out_color,
   output logic                               rsp_was_blended,
   output logic                               rsp_fully_masked,
   output logic [7:0]                         rsp_out_x,
   output logic [7:0]                         rsp_out_y,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lwpb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                        csr_wdata
);
   import lwpb_pkg::*;

   logic [3:0]  display_control_ff;
   logic [31:0] win0_rect_ff;
   logic [31:0] win1_rect_ff;
   logic [23:0] window_layers_ff;
   logic [7:0]  blend_control_ff;
   logic [9:0]  blend_alpha_ff;
   logic [4:0]  brightness_level_ff;
   logic [14:0] backdrop_color_ff;

   win_cfg_type   win_cfg;
   blend_cfg_type blend_cfg;
   cand_type      cand;
   logic          cand_valid;
   logic          cand_ready;
   pixel_type     pixel;
   logic          pixel_valid;
   logic          pixel_ready;

   // Register file; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         display_control_ff  <= 4'd0;
         win0_rect_ff        <= 32'd0;
         win1_rect_ff        <= 32'd0;
         window_layers_ff    <= 24'd0;
         blend_control_ff    <= 8'd0;
         blend_alpha_ff      <= 10'd0;
         brightness_level_ff <= 5'd0;
         backdrop_color_ff   <= 15'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_DISPLAY_CONTROL:  display_control_ff  <= csr_wdata[3:0];
            CSR_WIN0_RECT:        win0_rect_ff        <= csr_wdata;
            CSR_WIN1_RECT:        win1_rect_ff        <= csr_wdata;
            CSR_WINDOW_LAYERS:    window_layers_ff    <= csr_wdata[23:0];
            CSR_BLEND_CONTROL:    blend_control_ff    <= csr_wdata[7:0];
            CSR_BLEND_ALPHA:      blend_alpha_ff      <= csr_wdata[9:0];
            CSR_BRIGHTNESS_LEVEL: brightness_level_ff <= csr_wdata[4:0];
            CSR_BACKDROP_COLOR:   backdrop_color_ff   <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // Configuration views for the two stages that use it.
   always_comb begin
      win_cfg.win_enable          = display_control_ff[3:1];
      win_cfg.win0_rect           = win0_rect_ff;
      win_cfg.win1_rect           = win1_rect_ff;
      win_cfg.window_layers       = window_layers_ff;
      blend_cfg.force_blank       = display_control_ff[0];
      blend_cfg.blend_control     = blend_control_ff;
      blend_cfg.blend_alpha       = blend_alpha_ff;
      blend_cfg.brightness_level  = brightness_level_ff;
   end

   lwpb_window u_window (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (win_cfg),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_pixel_x           (req_pixel_x),
      .req_pixel_y           (req_pixel_y),
      .req_obj_window_hit    (req_obj_window_hit),
      .req_layer_id          (req_layer_id),
      .req_layer_priority    (req_layer_priority),
      .req_layer_color       (req_layer_color),
      .req_candidate_present (req_candidate_present),
      .req_semi_transparent  (req_semi_transparent),
      .req_last_of_pixel     (req_last_of_pixel),
      .out_valid             (cand_valid),
      .out_item              (cand),
      .out_ready             (cand_ready)
   );

   lwpb_rank u_rank (
      .clock          (clock),
      .reset          (reset),
      .backdrop_color (backdrop_color_ff),
      .in_valid       (cand_valid),
      .in_item        (cand),
      .in_ready       (cand_ready),
      .out_valid      (pixel_valid),
      .out_pixel      (pixel),
      .out_ready      (pixel_ready)
   );

   lwpb_blend u_blend (
      .clock            (clock),
      .reset            (reset),
      .cfg              (blend_cfg),
      .in_valid         (pixel_valid),
      .in_pixel         (pixel),
      .in_ready         (pixel_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_color    (rsp_out_color),
      .rsp_was_blended  (rsp_was_blended),
      .rsp_fully_masked (rsp_fully_masked),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y)
   );

endmodule

>>> verif/tb_layer_window_priority_blend.sv
`timescale 1ns / 1ps

module tb_layer_window_priority_blend;
   import lwpb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned RANDOM_PHASES = 11;
   localparam int unsigned BEATS_PER_PHASE = 120;

   // Layer codes and display control bits used by the directed pixels.
   localparam logic [2:0] LAYER_BG0 = 3'd0;
   localparam logic [2:0] LAYER_BG1 = 3'd1;
   localparam logic [2:0] LAYER_BG2 = 3'd2;
   localparam logic [2:0] LAYER_BG3 = 3'd3;
   localparam logic [2:0] LAYER_UNUSED = 3'd7;
   localparam logic [3:0] DC_BLANK = 4'h1;
   localparam logic [3:0] DC_WIN0 = 4'h2;
   localparam logic [3:0] DC_WIN1 = 4'h4;
   localparam logic [3:0] DC_OBJWIN = 4'h8;

   typedef struct packed {
      logic [7:0]  x;
      logic [7:0]  y;
      logic        objhit;
      logic [2:0]  id;
      logic [1:0]  prio;
      logic [14:0] color;
      logic        present;
      logic        semi;
      logic        last;
   } layer_cand_type;

   typedef struct packed {
      logic [14:0] color;
      logic        blended;
      logic        masked;
      logic [7:0]  x;
      logic [7:0]  y;
   } pixel_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   layer_cand_type req_beat = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [14:0] rsp_out_color;
   logic rsp_was_blended;
   logic rsp_fully_masked;
   logic [7:0] rsp_out_x;
   logic [7:0] rsp_out_y;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // Candidates waiting to be sent and pixels waiting to come out.
   layer_cand_type beat_queue[$];
   pixel_out_type pixel_queue[$];

   // Register copy used by the pixel predictor.
   logic [3:0]  cfg_display = '0;
   logic [31:0] cfg_win0 = '0;
   logic [31:0] cfg_win1 = '0;
   logic [23:0] cfg_win_layers = '0;
   logic [7:0]  cfg_blend = '0;
   logic [9:0]  cfg_alpha = '0;
   logic [4:0]  cfg_bright = '0;
   logic [14:0] cfg_backdrop = '0;

   // Ranking state of the pixel being assembled.
   logic [14:0] top_color = '0;
   logic [2:0]  top_layer = LAYER_BACKDROP;
   logic [2:0]  top_rank = RANK_BACKDROP;
   logic [14:0] under_color = '0;
   logic [2:0]  under_rank = RANK_BACKDROP;
   logic        top_semi = 1'b0;
   logic        pixel_fresh = 1'b1;

   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   logic no_gaps = 1'b0;
   int unsigned send_wait = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   int unsigned hold_arm = 0;
   int unsigned hold_seen = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned beats_taken = 0;
   int unsigned pixels_seen = 0;
   int unsigned blended_seen = 0;
   int unsigned masked_seen = 0;
   int unsigned regs_written = 0;

   layer_window_priority_blend dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_pixel_x           (req_beat.x),
      .req_pixel_y           (req_beat.y),
      .req_obj_window_hit    (req_beat.objhit),
      .req_layer_id          (req_beat.id),
      .req_layer_priority    (req_beat.prio),
      .req_layer_color       (req_beat.color),
      .req_candidate_present (req_beat.present),
      .req_semi_transparent  (req_beat.semi),
      .req_last_of_pixel     (req_beat.last),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_color         (rsp_out_color),
      .rsp_was_blended       (rsp_was_blended),
      .rsp_fully_masked      (rsp_fully_masked),
      .rsp_out_x             (rsp_out_x),
      .rsp_out_y             (rsp_out_y),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial forever #1 clock = ~clock;

   // Window hit test on one axis; an inverted range wraps around.
   function automatic logic span_hit(logic [7:0] c, logic [7:0] s, logic [7:0] e);
      return (s <= e) ? (c >= s && c < e) : (c >= s || c < e);
   endfunction

   function automatic logic rect_hit(logic [31:0] r, logic [7:0] x, logic [7:0] y);
      return span_hit(x, r[7:0], r[15:8]) && span_hit(y, r[23:16], r[31:24]);
   endfunction

   // Layer and effect enables for one pixel position.
   function automatic logic [5:0] window_enables(logic [7:0] x, logic [7:0] y, logic objhit);
      if (cfg_display[3:1] == 3'b000) return MASK_ALL;
      if (cfg_display[1] && rect_hit(cfg_win0, x, y)) return cfg_win_layers[5:0];
      if (cfg_display[2] && rect_hit(cfg_win1, x, y)) return cfg_win_layers[11:6];
      if (cfg_display[3] && objhit) return cfg_win_layers[23:18];
      return cfg_win_layers[17:12];
   endfunction

   // Weighted sum of two colors per channel, saturated at full intensity.
   function automatic logic [14:0] alpha_mix(logic [14:0] upper, logic [14:0] lower,
                                             logic [4:0] wa, logic [4:0] wb);
      logic [14:0] res;
      int unsigned ua;
      int unsigned ub;
      int unsigned v;
      res = '0;
      for (int k = 0; k < 3; k++) begin
         ua = 32'(upper[5*k +: 5]);
         ub = 32'(lower[5*k +: 5]);
         v = (ua * 32'(wa) + ub * 32'(wb)) >> 4;
         if (v > 32'(CH_MAX)) v = 32'(CH_MAX);
         res[5*k +: 5] = v[4:0];
      end
      return res;
   endfunction

   // Move each channel toward white or black by amt sixteenths.
   function automatic logic [14:0] fade_color(logic [14:0] c, int unsigned amt, logic up);
      logic [14:0] res;
      int unsigned ch;
      res = '0;
      for (int k = 0; k < 3; k++) begin
         ch = 32'(c[5*k +: 5]);
         if (up) ch = ch + (((32'(CH_MAX) - ch) * amt) >> 4);
         else ch = ch - ((ch * amt) >> 4);
         res[5*k +: 5] = ch[4:0];
      end
      return res;
   endfunction

   // Update the ranking with one accepted candidate; returns 1 when the
   // beat closes a pixel, with the expected pixel in px.
   function automatic logic rank_and_blend(input layer_cand_type c, output pixel_out_type px);
      logic [5:0] m;
      logic [2:0] rank;
      effect_type eff;
      logic first;
      logic forced;
      int unsigned amt;
      m = window_enables(c.x, c.y, c.objhit);
      rank = {1'b0, c.prio};
      px = '0;
      if (pixel_fresh) begin
         top_color = cfg_backdrop;
         top_layer = LAYER_BACKDROP;
         top_rank = RANK_BACKDROP;
         under_color = cfg_backdrop;
         under_rank = RANK_BACKDROP;
         top_semi = 1'b0;
         pixel_fresh = 1'b0;
      end
      if (c.present && c.id <= LAYER_SPRITE && m[c.id] &&
          !(c.id == LAYER_SPRITE && rank > top_rank)) begin
         if (rank <= top_rank) begin
            under_color = top_color;
            under_rank = top_rank;
            top_color = c.color;
            top_layer = c.id;
            top_rank = rank;
            top_semi = (c.id == LAYER_SPRITE) && c.semi;
         end else if (rank <= under_rank) begin
            under_color = c.color;
            under_rank = rank;
         end
      end
      if (!c.last) return 1'b0;

      px.color = top_color;
      px.masked = (m == 6'h00);
      px.x = c.x;
      px.y = c.y;
      if (cfg_display[0]) begin
         px.color = COLOR_WHITE;
         px.masked = 1'b0;
      end else if (m[EFFECTS_BIT]) begin
         eff = effect_type'(cfg_blend[7:6]);
         first = cfg_blend[top_layer];
         forced = (top_layer == LAYER_SPRITE) && top_semi;
         if (forced || (eff == EFFECT_ALPHA && first)) begin
            px.color = alpha_mix(top_color, under_color, cfg_alpha[4:0], cfg_alpha[9:5]);
            px.blended = 1'b1;
         end else if ((eff == EFFECT_BRIGHTEN || eff == EFFECT_DARKEN) && first) begin
            amt = (cfg_bright > BRIGHT_MAX) ? 32'(BRIGHT_MAX) : 32'(cfg_bright);
            if (amt != 0) begin
               px.color = fade_color(top_color, amt, eff == EFFECT_BRIGHTEN);
               px.blended = 1'b1;
            end
         end
      end
      pixel_fresh = 1'b1;
      return 1'b1;
   endfunction

   function automatic void apply_reg(csr_index_type idx, logic [31:0] val);
      case (idx)
         CSR_DISPLAY_CONTROL: cfg_display = val[3:0];
         CSR_WIN0_RECT: cfg_win0 = val;
         CSR_WIN1_RECT: cfg_win1 = val;
         CSR_WINDOW_LAYERS: cfg_win_layers = val[23:0];
         CSR_BLEND_CONTROL: cfg_blend = val[7:0];
         CSR_BLEND_ALPHA: cfg_alpha = val[9:0];
         CSR_BRIGHTNESS_LEVEL: cfg_bright = val[4:0];
         CSR_BACKDROP_COLOR: cfg_backdrop = val[14:0];
         default: ;
      endcase
   endfunction

   function automatic int unsigned draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 6);
   endfunction

   task automatic check_field(string what, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
         mismatches++;
      end
   endtask

   // Sample both channels at the rising edge: predict accepted candidates
   // and compare each pixel beat with the oldest expectation.
   always @(posedge clock) begin : monitor
      pixel_out_type want;
      req_took <= req_valid && req_ready;
      rsp_took <= rsp_valid && rsp_ready;
      if (!reset && req_valid && req_ready) begin
         beats_taken++;
         if (rank_and_blend(req_beat, want)) pixel_queue.push_back(want);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_queue.size() == 0) begin
            $display("%0t: unexpected pixel beat, expected none, got (%0d,%0d) color %0h",
                     $time, rsp_out_x, rsp_out_y, rsp_out_color);
            mismatches++;
         end else begin
            want = pixel_queue.pop_front();
            check_field("out_color", 32'(want.color), 32'(rsp_out_color));
            check_field("was_blended", 32'(want.blended), 32'(rsp_was_blended));
            check_field("fully_masked", 32'(want.masked), 32'(rsp_fully_masked));
            check_field("out_x", 32'(want.x), 32'(rsp_out_x));
            check_field("out_y", 32'(want.y), 32'(rsp_out_y));
            pixels_seen++;
            if (rsp_was_blended) blended_seen++;
            if (rsp_fully_masked) masked_seen++;
         end
      end
   end

   // Candidate driver: holds a beat until it is taken, then waits its gap.
   always @(negedge clock) begin : feeder
      if (!reset) begin
         if (req_valid && !req_took) begin
            // Beat still waiting for the block.
         end else if (send_wait != 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (beat_queue.size() != 0) begin
            req_beat <= beat_queue.pop_front();
            req_valid <= 1'b1;
            send_wait <= draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Pixel receiver: a random stall after every beat, and a long hold-off
   // whenever the stimulus asks for one.
   always @(negedge clock) begin : sink
      int unsigned d;
      if (!reset) begin
         d = draw_gap();
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (hold_seen != hold_arm) begin
            hold_seen <= hold_arm;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (rsp_took && d != 0) begin
            rsp_ready <= 1'b0;
            stall_left <= d - 1;
         end else if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d pixels outstanding", $time, pixel_queue.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, val);
      regs_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_config(logic [31:0] dc, logic [31:0] w0, logic [31:0] w1,
                              logic [31:0] wl, logic [31:0] bc, logic [31:0] ba,
                              logic [31:0] bl, logic [31:0] bd);
      write_reg(CSR_DISPLAY_CONTROL, dc);
      write_reg(CSR_WIN0_RECT, w0);
      write_reg(CSR_WIN1_RECT, w1);
      write_reg(CSR_WINDOW_LAYERS, wl);
      write_reg(CSR_BLEND_CONTROL, bc);
      write_reg(CSR_BLEND_ALPHA, ba);
      write_reg(CSR_BRIGHTNESS_LEVEL, bl);
      write_reg(CSR_BACKDROP_COLOR, bd);
   endtask

   // Wait until every pixel has come out, then let the pipeline settle.
   task automatic wait_idle();
      @(posedge clock);
      while (beat_queue.size() != 0 || req_valid || pixel_queue.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic queue_beat(logic [7:0] x, logic [7:0] y, logic objhit, logic [2:0] id,
                             logic [1:0] prio, logic [14:0] color, logic present,
                             logic semi, logic last);
      layer_cand_type c;
      c.x = x;
      c.y = y;
      c.objhit = objhit;
      c.id = id;
      c.prio = prio;
      c.color = color;
      c.present = present;
      c.semi = semi;
      c.last = last;
      beat_queue.push_back(c);
   endtask

   // One pixel of n candidates with random content; a few beats carry
   // stray coordinates or close the pixel early.
   task automatic queue_pixel(int unsigned n);
      layer_cand_type c;
      logic [7:0] px;
      logic [7:0] py;
      logic hit;
      px = 8'($urandom_range(0, 255));
      py = 8'($urandom_range(0, 255));
      hit = 1'($urandom_range(0, 1));
      for (int unsigned k = 0; k < n; k++) begin
         c.x = px;
         c.y = py;
         c.objhit = hit;
         if ($urandom_range(0, 9) == 0) begin
            c.x = 8'($urandom_range(0, 255));
            c.y = 8'($urandom_range(0, 255));
            c.objhit = 1'($urandom_range(0, 1));
         end
         c.id = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(5, 7)) :
                                               3'($urandom_range(0, 4));
         c.prio = 2'($urandom_range(0, 3));
         c.color = 15'($urandom_range(0, 32767));
         c.present = ($urandom_range(0, 9) != 0);
         c.semi = 1'($urandom_range(0, 1));
         c.last = (k == n - 1) || ($urandom_range(0, 29) == 0);
         beat_queue.push_back(c);
      end
   endtask

   task automatic random_config(int unsigned ph);
      logic [3:0] dc;
      logic [7:0] bc;
      dc = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 4) != 0) dc[0] = 1'b0;
      bc = 8'($urandom_range(0, 255));
      bc[7:6] = ph[1:0];
      load_config(32'(dc), $urandom, $urandom, $urandom, 32'(bc), $urandom, $urandom,
                  $urandom);
   endtask

   initial begin
      int unsigned queued;
      int unsigned n;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // No windows, alpha on background 0: backdrop-only pixel, plain alpha,
      // ignored layer codes, dropped sprite, semi-transparent sprite and a tie.
      load_config(0, 0, 0, 0, 32'({EFFECT_ALPHA, 6'h01}), 32'({5'd8, 5'd8}), 0,
                  32'(15'h1234));
      queue_beat(0, 0, 0, LAYER_BG0, 0, 15'h0000, 0, 0, 1);
      queue_beat(255, 255, 1, LAYER_BG1, 2, 15'h7C00, 1, 0, 0);
      queue_beat(255, 255, 1, LAYER_BG0, 1, 15'h001F, 1, 0, 1);
      queue_beat(10, 20, 0, LAYER_UNUSED, 0, 15'h7FFF, 1, 0, 0);
      queue_beat(10, 20, 0, LAYER_BACKDROP, 0, 15'h7FFF, 1, 0, 0);
      queue_beat(10, 20, 0, LAYER_BG2, 3, 15'h03FF, 1, 0, 1);
      queue_beat(1, 1, 0, LAYER_SPRITE, 2, 15'h5555, 1, 1, 0);
      queue_beat(1, 1, 0, LAYER_SPRITE, 3, 15'h2AAA, 1, 0, 0);
      queue_beat(1, 1, 0, LAYER_BG3, 3, 15'h7FFF, 1, 0, 1);
      queue_beat(2, 2, 0, LAYER_SPRITE, 1, 15'h7FFF, 1, 1, 0);
      queue_beat(2, 2, 0, LAYER_BG0, 1, 15'h0421, 1, 0, 1);
      wait_idle();

      // Brighten with an oversized factor, including the backdrop as target.
      load_config(0, 0, 0, 0, 32'({EFFECT_BRIGHTEN, 6'h3F}), 0, 31, 32'(15'h0C63));
      queue_beat(3, 3, 0, LAYER_BG0, 0, 15'h0000, 0, 0, 1);
      queue_beat(3, 3, 0, LAYER_BG1, 0, 15'h4210, 1, 0, 1);
      wait_idle();

      // Darken with a zero factor leaves the pixel alone; then a real one.
      load_config(0, 0, 0, 0, 32'({EFFECT_DARKEN, 6'h3F}), 0, 0, 0);
      queue_beat(4, 4, 0, LAYER_BG0, 0, 15'h7FFF, 1, 0, 1);
      wait_idle();
      load_config(0, 0, 0, 0, 32'({EFFECT_DARKEN, 6'h3F}), 0, 9, 0);
      queue_beat(4, 4, 0, LAYER_BG0, 0, 15'h7FFF, 1, 0, 1);
      wait_idle();

      // All three windows: inside window 0, inside the wrapped window 1,
      // outside with an empty mask, sprite window, exclusive edges, and a
      // pixel whose window is taken from its last beat.
      load_config(32'(DC_WIN0 | DC_WIN1 | DC_OBJWIN), {8'd20, 8'd10, 8'd20, 8'd10},
                  {8'd50, 8'd200, 8'd50, 8'd200}, 32'({6'h30, 6'h00, 6'h01, 6'h3F}),
                  32'({EFFECT_ALPHA, 6'h01}), 32'({5'd31, 5'd31}), 0, 32'(15'h7FFF));
      queue_beat(15, 15, 0, LAYER_BG0, 0, 15'h7FFF, 1, 0, 1);
      queue_beat(250, 250, 0, LAYER_BG1, 0, 15'h1111, 1, 0, 1);
      queue_beat(100, 100, 0, LAYER_BG0, 0, 15'h2222, 1, 0, 1);
      queue_beat(100, 100, 1, LAYER_SPRITE, 0, 15'h001F, 1, 1, 1);
      queue_beat(15, 15, 0, LAYER_BG0, 0, 15'h03E0, 1, 0, 0);
      queue_beat(100, 100, 0, LAYER_BG0, 0, 15'h0000, 0, 0, 1);
      queue_beat(20, 20, 0, LAYER_BG0, 0, 15'h7C1F, 1, 0, 1);
      wait_idle();

      // Forced blank.
      load_config(32'(DC_BLANK), 0, 0, 0, 0, 0, 0, 0);
      queue_beat(5, 5, 0, LAYER_BG0, 0, 15'h1234, 1, 0, 1);
      wait_idle();

      // Random phases: all-zero and all-one registers first, then random
      // settings cycling through the effects. One phase runs without gaps
      // and one starts with a long receiver hold-off.
      for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0) load_config(0, 0, 0, 0, 0, 0, 0, 0);
         else if (ph == 1)
            load_config('1, '1, '1, '1, '1, '1, '1, '1);
         else random_config(ph);
         no_gaps = (ph == 4);
         if (ph == 6) hold_arm++;
         queued = 0;
         while (queued < BEATS_PER_PHASE) begin
            n = $urandom_range(1, 5);
            queue_pixel(n);
            queued += n;
         end
         wait_idle();
      end

      $display("Covered %0d pixels (%0d blended, %0d fully masked) from %0d candidate beats",
               pixels_seen, blended_seen, masked_seen, beats_taken);
      $display("across %0d register writes with windows, priorities and all effects.",
               regs_written);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
